// ----- sv/sesb_pkg.sv -----
package sesb_pkg;

    localparam int MAX_SHELLS = 64;
    localparam int SHELL_W    = 6;
    localparam int ACC_W      = 56;
    localparam int CONTRIB_W  = 34;
    localparam int ROOT_W     = 24;
    localparam int INV_W      = 24;
    localparam int ADDR_W     = 4;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    // Configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_COSINE_KIND    = 2'd0;
    localparam logic [1:0] REG_INV_SHELL_STEP = 2'd1;
    localparam logic [1:0] REG_NUM_SHELLS     = 2'd2;

    typedef struct packed {
        logic signed [15:0] coeff_re;
        logic signed [15:0] coeff_im;
        logic [31:0]        wave_number_sq;
        logic               kz_is_zero;
        logic               ky_is_zero;
        logic               last_coeff;
    } coeff_t;

    typedef struct packed {
        logic [SHELL_W-1:0] shell_index;
        logic [ACC_W-1:0]   shell_energy;
        logic               last_shell;
    } result_t;

    // Control broadcast to every accumulator cell
    typedef struct packed {
        logic                 clear;
        logic                 shift;
        logic                 add;
        logic [SHELL_W-1:0]   shell;
        logic [CONTRIB_W-1:0] contrib;
    } cell_ctl_t;

endpackage

// ----- sv/sesb_cell.sv -----
module sesb_cell
    import sesb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctl_t          ctl,
    input  logic [SHELL_W-1:0] cell_index,
    input  logic [ACC_W-1:0]   shift_in,
    output logic [ACC_W-1:0]   acc
);

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W:0]   sum;

    // Saturating add of the broadcast contribution
    assign sum = {1'b0, acc_reg} + (ACC_W+1)'(ctl.contrib);

    always_comb
    begin
        acc_next = acc_reg;
        priority if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.shift)
        begin
            acc_next = shift_in;
        end
        else if (ctl.add && (ctl.shell == cell_index))
        begin
            acc_next = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ----- sv/sesb_root.sv -----
module sesb_root
    import sesb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       k2,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int SH_W  = REM_W + 2;

    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [SH_W-1:0]   rem_sh, trial, diff;
    logic              fits;

    // One root bit per cycle, restoring method
    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign diff   = rem_sh - trial;
    assign fits   = (rem_sh >= trial);

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        rad_next    = rad_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        done_next   = 1'b0;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = 5'(ROOT_W - 1);
            rad_next    = {k2, 16'h0000};
            rem_next    = '0;
            root_next   = '0;
        end
        else if (active_reg)
        begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], fits};
            cnt_next  = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- sv/shell_energy_spectrum_binning_top.sv -----
// Shell energy spectrum binning. Raise start with a coefficient while busy is low;
// the coefficient is taken at that edge. Each coefficient keeps busy high through
// the bit-serial square root of the wave number, then one multiply and one
// accumulate into a row of 64 accumulator cells, so a new coefficient is taken
// only after the previous one has been accumulated. A coefficient marked
// last_coeff additionally shifts the cell row out through the scaling multiplier,
// one shell per cycle, so result_valid is high on consecutive cycles, one per
// shell in use, behind the scaling registers; busy stays high until the final
// shell (marked last_shell) has been presented and the row is cleared. Results
// cannot be held off: capture every cycle in which result_valid is high.
// Configure through the APB port only while busy is low.
module shell_energy_spectrum_binning_top
    import sesb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  coeff_t            coeff,
    output logic              busy,
    output logic              result_valid,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ROOT  = 5'b00010,
        S_MUL   = 5'b00100,
        S_EMIT  = 5'b01000,
        S_DRAIN = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic             cosine_kind_reg;
    logic [INV_W-1:0] inv_reg;
    logic [6:0]       num_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cosine_kind_reg <= 1'b0;
            inv_reg         <= 24'd65536;
            num_reg         <= 7'd64;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_COSINE_KIND:    cosine_kind_reg <= pwdata[0];
                REG_INV_SHELL_STEP: inv_reg         <= pwdata[INV_W-1:0];
                REG_NUM_SHELLS:     num_reg         <= pwdata[6:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_COSINE_KIND:    prdata = {31'd0, cosine_kind_reg};
            REG_INV_SHELL_STEP: prdata = {8'd0, inv_reg};
            REG_NUM_SHELLS:     prdata = {25'd0, num_reg};
            default:            prdata = '0;
        endcase
    end

    // Index of the last shell in use
    logic [SHELL_W-1:0] last_idx;
    always_comb
    begin
        priority if (num_reg == 7'd0)
        begin
            last_idx = '0;
        end
        else if (num_reg > 7'(MAX_SHELLS))
        begin
            last_idx = SHELL_W'(MAX_SHELLS - 1);
        end
        else
        begin
            last_idx = 6'(num_reg - 7'd1);
        end
    end

    // Capture coefficient: weighted magnitude and flags
    logic                 accept;
    logic signed [31:0]   sq_re, sq_im;
    logic [31:0]          mag;
    logic [1:0]           shamt;
    logic                 drop;
    logic [CONTRIB_W-1:0] contrib_reg;
    logic                 drop_reg;
    logic                 last_reg;

    assign accept = start && !busy;
    assign sq_re  = 32'(coeff.coeff_re) * 32'(coeff.coeff_re);
    assign sq_im  = 32'(coeff.coeff_im) * 32'(coeff.coeff_im);
    assign mag    = 32'(sq_re) + 32'(sq_im);
    assign drop   = coeff.kz_is_zero && !cosine_kind_reg;
    assign shamt  = (coeff.kz_is_zero ? 2'd2 : 2'd1) - {1'b0, coeff.ky_is_zero};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            contrib_reg <= {2'b00, mag} << shamt;
            drop_reg    <= drop;
            last_reg    <= coeff.last_coeff;
        end
    end

    // Square root unit
    logic              root_done;
    logic [ROOT_W-1:0] root;

    sesb_root u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .k2    (coeff.wave_number_sq),
        .done  (root_done),
        .root  (root)
    );

    // Shell number product
    logic [ROOT_W+INV_W-1:0] prod_reg;
    logic [15:0]             shell_raw;
    logic [SHELL_W-1:0]      shell;

    always_ff @(posedge clk)
    begin
        if (root_done)
        begin
            prod_reg <= (ROOT_W+INV_W)'(root) * (ROOT_W+INV_W)'(inv_reg);
        end
    end

    assign shell_raw = prod_reg[ROOT_W+INV_W-1 -: 16];
    assign shell     = (shell_raw > 16'(last_idx)) ? last_idx : shell_raw[SHELL_W-1:0];

    // Sequencer
    logic [SHELL_W-1:0] cnt_reg, cnt_next;
    cell_ctl_t          ctl;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ctl.clear   = 1'b0;
        ctl.shift   = 1'b0;
        ctl.add     = 1'b0;
        ctl.shell   = shell;
        ctl.contrib = contrib_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (root_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                ctl.add    = !drop_reg;
                cnt_next   = '0;
                state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                ctl.shift = 1'b1;
                cnt_next  = cnt_reg + SHELL_W'(1);
                if (cnt_reg == last_idx)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                ctl.clear  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Row of accumulator cells; emission shifts toward cell 0
    logic [ACC_W-1:0] acc [MAX_SHELLS];

    for (genvar i = 0; i < MAX_SHELLS; i++)
    begin : g_cell
        logic [ACC_W-1:0] nb;
        if (i == MAX_SHELLS - 1)
        begin : g_end
            assign nb = '0;
        end
        else
        begin : g_mid
            assign nb = acc[i+1];
        end
        sesb_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .cell_index (SHELL_W'(i)),
            .shift_in   (nb),
            .acc        (acc[i])
        );
    end

    // Scaling: split product, then combine and saturate
    localparam int HALF_W = ACC_W / 2;
    localparam int PP_W   = HALF_W + INV_W;

    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic [SHELL_W-1:0] s1_idx_reg;
    logic [PP_W-1:0]    hp_reg, lp_reg;
    logic [ACC_W:0]     scaled;
    logic               out_valid_reg;
    result_t            result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= (state_reg == S_EMIT);
            out_valid_reg <= s1_valid_reg;
        end
    end

    assign scaled = (ACC_W+1)'({hp_reg, 4'b0000})
                  + (ACC_W+1)'(lp_reg[PP_W-1:INV_W]);

    always_ff @(posedge clk)
    begin
        hp_reg      <= PP_W'(acc[0][ACC_W-1:HALF_W]) * PP_W'(inv_reg);
        lp_reg      <= PP_W'(acc[0][HALF_W-1:0]) * PP_W'(inv_reg);
        s1_idx_reg  <= cnt_reg;
        s1_last_reg <= (cnt_reg == last_idx);
        result_reg.shell_index  <= s1_idx_reg;
        result_reg.shell_energy <= scaled[ACC_W] ? ACC_MAX : scaled[ACC_W-1:0];
        result_reg.last_shell   <= s1_last_reg;
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;
    assign busy         = (state_reg != S_IDLE) || s1_valid_reg || out_valid_reg;

    // Checks
    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result while not busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");

    a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_shell) |=>
            (result_valid && result.shell_index == $past(result.shell_index) + SHELL_W'(1)))
        else $error("shell sequence broken");

    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> (result.shell_index == '0))
        else $error("emission does not start at shell zero");

endmodule

// ----- tb/tb_shell_energy_spectrum_binning_top.sv -----
module tb_shell_energy_spectrum_binning_top;
    import sesb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 300;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 32;

    typedef struct {
        bit                 is_cfg;
        logic [1:0]         reg_idx;
        logic [31:0]        reg_val;
        coeff_t             c;
        bit                 typed;
        logic [SHELL_W-1:0] t_shell;
        logic [ACC_W-1:0]   t_energy;
    } row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    coeff_t            coeff;
    logic              busy;
    logic              result_valid;
    result_t           result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Shadow state of the binning engine
    logic [ACC_W-1:0] shell_acc [MAX_SHELLS];
    logic             cos_kind;
    logic [INV_W-1:0] inv_step;
    logic [6:0]       shell_count;

    result_t spectrum_q [$];
    int      taken_cnt;
    int      stall_cnt;
    bit      failed;
    int      sender_idle;
    row_t    rows [$];

    shell_energy_spectrum_binning_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .coeff        (coeff),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Generate clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Integer square root, one result bit per pass
    function automatic logic [23:0] wave_root(logic [47:0] v);
        logic [23:0] r;
        logic [23:0] t;
        r = '0;
        for (int b = 23; b >= 0; b--)
        begin
            t = r | (24'd1 << b);
            if ({40'd0, t} * {40'd0, t} <= {16'd0, v})
                r = t;
        end
        return r;
    endfunction

    // Bin one coefficient and queue the spectrum when it closes the field
    task automatic bin_coefficient(coeff_t c);
        int               n;
        int               re;
        int               im;
        longint           mag;
        logic [23:0]      root;
        logic [47:0]      prod;
        int               shell;
        int               sh;
        bit               drop;
        logic [ACC_W:0]   sum;
        logic [79:0]      scaled;
        result_t          r;
        n = shell_count;
        if (n < 1)
            n = 1;
        if (n > MAX_SHELLS)
            n = MAX_SHELLS;
        re = c.coeff_re;
        im = c.coeff_im;
        mag = longint'(re) * re + longint'(im) * im;
        root = wave_root({c.wave_number_sq, 16'd0});
        prod = {24'd0, root} * {24'd0, inv_step};
        shell = int'(prod >> 32);
        if (shell > n - 1)
            shell = n - 1;
        drop = 1'b0;
        if (!c.kz_is_zero)
            sh = 1;
        else if (cos_kind)
            sh = 2;
        else
        begin
            sh = 0;
            drop = 1'b1;
        end
        if (c.ky_is_zero)
            sh = sh - 1;
        if (!drop)
        begin
            sum = {1'b0, shell_acc[shell]} + ((sh > 0) ? (mag << sh) : mag);
            shell_acc[shell] = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_W-1:0];
        end
        if (c.last_coeff)
        begin
            for (int i = 0; i < n; i++)
            begin
                scaled = ({24'd0, shell_acc[i]} * {56'd0, inv_step}) >> 24;
                r.shell_index  = i[SHELL_W-1:0];
                r.shell_energy = (scaled > ACC_MAX) ? ACC_MAX : scaled[ACC_W-1:0];
                r.last_shell   = (i == n - 1);
                spectrum_q.push_back(r);
            end
            for (int i = 0; i < MAX_SHELLS; i++)
                shell_acc[i] = '0;
        end
    endtask

    // Count accepted transactions and check emitted shells
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            taken_cnt <= taken_cnt + 1;
        if (rst_n && result_valid)
        begin
            if (spectrum_q.size() == 0)
            begin
                $display("%0t: unexpected shell idx=%0d energy=%0d last=%0b", $time,
                         result.shell_index, result.shell_energy, result.last_shell);
                failed <= 1'b1;
            end
            else
            begin
                if (result !== spectrum_q[0])
                begin
                    $display("%0t: shell mismatch exp idx=%0d energy=%0d last=%0b", $time,
                             spectrum_q[0].shell_index, spectrum_q[0].shell_energy,
                             spectrum_q[0].last_shell);
                    $display("%0t:                act idx=%0d energy=%0d last=%0b", $time,
                             result.shell_index, result.shell_energy, result.last_shell);
                    failed <= 1'b1;
                end
                void'(spectrum_q.pop_front());
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Hold until the engine has drained, then let a non-emitting item settle
    task automatic wait_idle();
        while (spectrum_q.size() != 0 || busy)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        wait_idle();
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_COSINE_KIND:    cos_kind    = val[0];
            REG_INV_SHELL_STEP: inv_step    = val[INV_W-1:0];
            REG_NUM_SHELLS:     shell_count = val[6:0];
            default: ;
        endcase
    endtask

    // Present one coefficient and hold it until taken
    task automatic send_coeff(coeff_t c, output int first_exp);
        int seen;
        while ($urandom_range(99) < sender_idle)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        seen  = taken_cnt;
        start = 1'b1;
        coeff = c;
        do
            @(negedge clk);
        while (taken_cnt == seen);
        start = 1'b0;
        first_exp = spectrum_q.size();
        bin_coefficient(c);
    endtask

    function automatic coeff_t mk(int re, int im, logic [31:0] k2, bit kz, bit ky, bit last);
        coeff_t c;
        c.coeff_re       = re[15:0];
        c.coeff_im       = im[15:0];
        c.wave_number_sq = k2;
        c.kz_is_zero     = kz;
        c.ky_is_zero     = ky;
        c.last_coeff     = last;
        return c;
    endfunction

    function automatic row_t item_row(coeff_t c, bit typed = 0, int t_shell = 0,
                                      logic [ACC_W-1:0] t_energy = '0);
        row_t r;
        r.is_cfg   = 1'b0;
        r.reg_idx  = '0;
        r.reg_val  = '0;
        r.c        = c;
        r.typed    = typed;
        r.t_shell  = t_shell[SHELL_W-1:0];
        r.t_energy = t_energy;
        return r;
    endfunction

    function automatic row_t cfg_row(logic [1:0] idx, logic [31:0] val);
        row_t r;
        r = item_row('0);
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic coeff_t rand_coeff();
        coeff_t c;
        c.coeff_re = 16'($urandom);
        c.coeff_im = 16'($urandom);
        case ($urandom_range(3))
            0:       c.wave_number_sq = $urandom;
            1:       c.wave_number_sq = $urandom_range(32'h0400_0000);
            default: c.wave_number_sq = $urandom_range(32'h0010_0000);
        endcase
        c.kz_is_zero = 1'($urandom_range(1));
        c.ky_is_zero = 1'($urandom_range(1));
        c.last_coeff = ($urandom_range(11) == 0);
        return c;
    endfunction

    initial
    begin
        int      first;
        coeff_t  c;
        start       = 1'b0;
        coeff       = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        rst_n       = 1'b0;
        taken_cnt   = 0;
        stall_cnt   = 0;
        failed      = 1'b0;
        sender_idle = 0;
        cos_kind    = 1'b0;
        inv_step    = 24'd65536;
        shell_count = 7'd64;
        for (int i = 0; i < MAX_SHELLS; i++)
            shell_acc[i] = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table: reset settings, extremes, weights, clamping, registers
        rows.push_back(item_row(mk(-32768, -32768, 0, 0, 0, 1), 1, 0, 56'd16777216));
        rows.push_back(item_row(mk(32767, 0, 32'h0001_0000, 0, 0, 0)));
        rows.push_back(item_row(mk(0, 32767, 0, 1, 0, 0)));
        rows.push_back(item_row(mk(100, -100, 32'h0003_0000, 0, 1, 0)));
        rows.push_back(item_row(mk(-1, 1, 32'hFFFF_FFFF, 1, 1, 1)));
        rows.push_back(cfg_row(REG_COSINE_KIND, 1));
        rows.push_back(cfg_row(REG_NUM_SHELLS, 2));
        rows.push_back(cfg_row(REG_INV_SHELL_STEP, 32'h00FF_FFFF));
        rows.push_back(item_row(mk(32767, 32767, 32'h0001_0000, 1, 1, 0)));
        rows.push_back(item_row(mk(-32768, 32767, 32'hFFFF_FFFF, 1, 0, 0)));
        rows.push_back(item_row(mk(12345, -2222, 0, 0, 1, 1)));
        rows.push_back(cfg_row(REG_INV_SHELL_STEP, 0));
        rows.push_back(item_row(mk(-32768, -32768, 32'hFFFF_FFFF, 1, 0, 1), 1, 0, 56'd0));
        rows.push_back(cfg_row(REG_NUM_SHELLS, 1));
        rows.push_back(cfg_row(REG_INV_SHELL_STEP, 32'h0001_0000));
        rows.push_back(item_row(mk(-32768, 0, 32'h0100_0000, 1, 0, 1), 1, 0, 56'd16777216));
        rows.push_back(cfg_row(REG_NUM_SHELLS, 0));
        rows.push_back(item_row(mk(7, 9, 32'h0004_0000, 0, 0, 1)));
        rows.push_back(cfg_row(REG_NUM_SHELLS, 127));
        rows.push_back(item_row(mk(-32768, -32768, 32'h1000_0000, 1, 1, 1)));
        rows.push_back(cfg_row(REG_COSINE_KIND, 0));
        rows.push_back(cfg_row(REG_NUM_SHELLS, 64));

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            else
            begin
                send_coeff(rows[i].c, first);
                if (rows[i].typed && (spectrum_q.size() <= first + rows[i].t_shell ||
                    spectrum_q[first + rows[i].t_shell].shell_energy !== rows[i].t_energy))
                begin
                    $display("%0t: directed row %0d shell %0d energy exp=%0d", $time, i,
                             rows[i].t_shell, rows[i].t_energy);
                    failed = 1'b1;
                end
            end
        end

        // Random items in three idling phases, new settings before each
        for (int ph = 0; ph < 3; ph++)
        begin
            sender_idle = (ph == 0) ? 32 : (ph == 1) ? 84 : 0;
            if (ph == 1)
                write_reg(REG_COSINE_KIND, 1);
            write_reg(REG_INV_SHELL_STEP, (ph == 2) ? $urandom : $urandom_range(32'h0004_0000));
            write_reg(REG_NUM_SHELLS, (ph == 0) ? 64 : $urandom_range(2, 64));
            for (int k = 0; k < N_RANDOM / 3; k++)
            begin
                c = rand_coeff();
                if (k == N_RANDOM / 3 - 1)
                    c.last_coeff = 1'b1;
                send_coeff(c, first);
            end
        end

        // Drain the spectrum queue, then let the tail settle
        while (spectrum_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (!failed)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/sesb_pkg.sv
sv/sesb_cell.sv
sv/sesb_root.sv
sv/shell_energy_spectrum_binning_top.sv
tb/tb_shell_energy_spectrum_binning_top.sv
